// ===== hdl/i2ra_pkg.sv =====
// shared constants, types and the digit glyph lookup for the integer to ascii converter
// no dependencies; imported by i2ra_div, integer_to_radix_ascii_core and its test
package i2ra_pkg;

    localparam int VALUE_WIDTH = 64;
    localparam int IN_VALUE_W  = 64;
    localparam int RADIX_IN_W  = 8;
    localparam int LIMIT_W     = 7;
    localparam int S_TDATA_W   = 80;
    localparam int S_TUSER_W   = 1;
    localparam int CHAR_W      = 8;

    localparam int DIGIT_W     = 4;
    localparam int RADIX_W     = DIGIT_W + 1;
    localparam int STORE_DEPTH = 64;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int COUNT_W     = ADDR_W + 1;
    localparam int STEP_W      = $clog2(VALUE_WIDTH);

    localparam logic [RADIX_IN_W-1:0] RADIX_MIN  = RADIX_IN_W'(2);
    localparam logic [RADIX_IN_W-1:0] RADIX_MAX  = RADIX_IN_W'(16);
    localparam logic [LIMIT_W-1:0]    MAX_CHARS  = LIMIT_W'(STORE_DEPTH);
    localparam logic [CHAR_W-1:0]     MINUS_CHAR = 8'h2D;
    localparam logic [CHAR_W-1:0]     ZERO_CHAR  = 8'h30;
    localparam logic [CHAR_W-1:0]     ALPHA_CHAR = 8'h41;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } div_res_t;

    function automatic logic [CHAR_W-1:0] glyph(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] ch;
        if (d < DIGIT_W'(10)) begin
            ch = ZERO_CHAR + CHAR_W'(d);
        end else begin
            ch = ALPHA_CHAR + CHAR_W'(d - DIGIT_W'(10));
        end
        return ch;
    endfunction

endpackage

// ===== hdl/integer_to_radix_ascii_core.sv =====
// integer to ascii conversion in radix 2..16: sequencer, digit store and output register
// depends on i2ra_pkg, i2ra_div and i2ra_ram
// each digit takes a test, a division by the bit-serial divider and a store; then an init
// state, and each character passes select, load and output states (the minus sign skips load)
// the conversion time of a long value is set mostly by the bit-serial divider
// one item at a time: s_tready is high only when the previous item is fully emitted
// aresetn is synchronous and active low; it clears the sequencer and the divider
// control, the digit store holds no reset state
module integer_to_radix_ascii_core (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [i2ra_pkg::S_TDATA_W-1:0]   s_tdata,  // value_bits, radix_request, out_limit
    input  logic [i2ra_pkg::S_TUSER_W-1:0]   s_tuser,  // signed_mode
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [i2ra_pkg::CHAR_W-1:0]      m_tdata,  // out_char
    output logic                             m_tlast
);
    import i2ra_pkg::*;

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_TEST = 7'b0000010,
        ST_DIV  = 7'b0000100,
        ST_INIT = 7'b0001000,
        ST_SEL  = 7'b0010000,
        ST_LOAD = 7'b0100000,
        ST_OUT  = 7'b1000000
    } state_t;

    state_t                 state_reg, state_next;
    logic [VALUE_WIDTH-1:0] quot_reg, quot_next;
    logic [RADIX_W-1:0]     radix_reg, radix_next;
    logic [LIMIT_W-1:0]     limit_reg, limit_next;
    logic                   neg_reg, neg_next;
    logic [COUNT_W-1:0]     count_reg, count_next;
    logic [COUNT_W-1:0]     pos_reg, pos_next;
    logic [COUNT_W-1:0]     left_reg, left_next;
    logic [CHAR_W-1:0]      char_reg, char_next;

    logic [VALUE_WIDTH-1:0] in_value;
    logic                   in_neg;
    logic [RADIX_IN_W-1:0]  in_radix;
    logic [LIMIT_W-1:0]     in_limit;
    logic [COUNT_W-1:0]     total;
    logic [COUNT_W-1:0]     emit;

    logic                   div_start;
    div_res_t               div_res;

    logic                   ram_we;
    logic [ADDR_W-1:0]      ram_waddr;
    logic [DIGIT_W-1:0]     ram_wdata;
    logic [ADDR_W-1:0]      ram_raddr;
    logic [DIGIT_W-1:0]     ram_rdata;

    assign in_value = s_tdata[VALUE_WIDTH-1:0];
    assign in_neg   = s_tuser[0] & in_value[VALUE_WIDTH-1];
    assign in_radix = s_tdata[IN_VALUE_W +: RADIX_IN_W];
    assign in_limit = s_tdata[IN_VALUE_W + RADIX_IN_W +: LIMIT_W];

    assign total = count_reg + COUNT_W'(neg_reg);
    assign emit  = (total < COUNT_W'(limit_reg)) ? total : COUNT_W'(limit_reg);

    always_comb begin
        state_next = state_reg;
        quot_next  = quot_reg;
        radix_next = radix_reg;
        limit_next = limit_reg;
        neg_next   = neg_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        left_next  = left_reg;
        char_next  = char_reg;
        div_start  = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = count_reg[ADDR_W-1:0];
        ram_wdata  = div_res.remainder;
        ram_raddr  = ADDR_W'(pos_reg - COUNT_W'(1));
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    // magnitude taken modulo 2^width, so the most negative value works
                    quot_next  = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;
                    neg_next   = in_neg;
                    count_next = '0;
                    if (in_radix < RADIX_MIN) begin
                        radix_next = RADIX_W'(RADIX_MIN);
                    end else if (in_radix > RADIX_MAX) begin
                        radix_next = RADIX_W'(RADIX_MAX);
                    end else begin
                        radix_next = in_radix[RADIX_W-1:0];
                    end
                    limit_next = (in_limit > MAX_CHARS) ? MAX_CHARS : in_limit;
                    state_next = ST_TEST;
                end
            end
            ST_TEST: begin
                if (quot_reg != '0) begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end else begin
                    if (count_reg == '0) begin
                        // zero prints as a single digit
                        ram_we     = 1'b1;
                        ram_wdata  = '0;
                        count_next = COUNT_W'(1);
                    end
                    state_next = ST_INIT;
                end
            end
            ST_DIV: begin
                if (div_res.done) begin
                    ram_we     = 1'b1;
                    quot_next  = div_res.quotient;
                    count_next = count_reg + COUNT_W'(1);
                    state_next = ST_TEST;
                end
            end
            ST_INIT: begin
                left_next = emit;
                pos_next  = count_reg;
                if (emit == '0) begin
                    state_next = ST_IDLE;
                end else begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL: begin
                if (neg_reg) begin
                    char_next  = MINUS_CHAR;
                    neg_next   = 1'b0;
                    state_next = ST_OUT;
                end else begin
                    pos_next   = pos_reg - COUNT_W'(1);
                    state_next = ST_LOAD;
                end
            end
            ST_LOAD: begin
                char_next  = glyph(ram_rdata);
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (m_tready) begin
                    left_next = left_reg - COUNT_W'(1);
                    if (left_reg == COUNT_W'(1)) begin
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_SEL;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
        quot_reg  <= quot_next;
        radix_reg <= radix_next;
        limit_reg <= limit_next;
        neg_reg   <= neg_next;
        count_reg <= count_next;
        pos_reg   <= pos_next;
        left_reg  <= left_next;
        char_reg  <= char_next;
    end

    i2ra_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (quot_reg),
        .divisor  (radix_reg),
        .res      (div_res)
    );

    i2ra_ram #(
        .WIDTH (DIGIT_W),
        .DEPTH (STORE_DEPTH)
    ) u_digit_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = char_reg;
    assign m_tlast  = (left_reg == COUNT_W'(1));

`ifndef SYNTH
    a_one_side_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid))
        else $error("input ready while an item is pending on the output");
    a_store_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV) |-> (count_reg < COUNT_W'(STORE_DEPTH)))
        else $error("digit store overflow");
    a_digit_available: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SEL && !neg_reg) |-> (pos_reg != '0))
        else $error("digit read below the first stored digit");
    a_last_frees_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tready && m_tlast) |=> s_tready)
        else $error("input not ready after the last character");
    a_left_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (left_reg != '0))
        else $error("character pending with nothing left to emit");
`endif

endmodule

// ===== hdl/i2ra_ram.sv =====
// generic simple dual port ram, one write port and one registered read port
// no dependencies
module i2ra_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hdl/i2ra_div.sv =====
// bit-serial restoring divider: value by a radix of 2..16, one quotient bit per cycle
// depends on i2ra_pkg
module i2ra_div (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                start,
    input  logic [i2ra_pkg::VALUE_WIDTH-1:0]    dividend,
    input  logic [i2ra_pkg::RADIX_W-1:0]        divisor,
    output i2ra_pkg::div_res_t                  res
);
    import i2ra_pkg::*;

    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic [STEP_W-1:0]      step_reg, step_next;
    logic [VALUE_WIDTH-1:0] work_reg, work_next;
    logic [DIGIT_W-1:0]     rem_reg, rem_next;
    logic [RADIX_W-1:0]     divisor_reg, divisor_next;
    logic [RADIX_W-1:0]     trial;
    logic                   fits;

    // remainder stays below the divisor, so the trial fits in five bits
    assign trial = {rem_reg, work_reg[VALUE_WIDTH-1]};
    assign fits  = (trial >= divisor_reg);

    always_comb begin
        busy_next    = busy_reg;
        done_next    = 1'b0;
        step_next    = step_reg;
        work_next    = work_reg;
        rem_next     = rem_reg;
        divisor_next = divisor_reg;
        if (start && !busy_reg) begin
            busy_next    = 1'b1;
            step_next    = STEP_W'(VALUE_WIDTH - 1);
            work_next    = dividend;
            rem_next     = '0;
            divisor_next = divisor;
        end else if (busy_reg) begin
            work_next = {work_reg[VALUE_WIDTH-2:0], fits};
            rem_next  = fits ? DIGIT_W'(trial - divisor_reg) : trial[DIGIT_W-1:0];
            step_next = step_reg - STEP_W'(1);
            if (step_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        step_reg    <= step_next;
        work_reg    <= work_next;
        rem_reg     <= rem_next;
        divisor_reg <= divisor_next;
    end

    assign res.done      = done_reg;
    assign res.quotient  = work_reg;
    assign res.remainder = rem_reg;

`ifndef SYNTH
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("divider done without a running division");
    a_rem_below_divisor: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> (RADIX_W'(rem_reg) < divisor_reg))
        else $error("remainder not below divisor");
    a_no_done_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg)
        else $error("divider done while still busy");
`endif

endmodule

// ===== test/integer_to_radix_ascii_core_test.sv =====
// self-checking test of integer_to_radix_ascii_core: directed corner values, then random items
// checked character by character against a predictor that mirrors the radix conversion
// depends on i2ra_pkg and the core rtl
module integer_to_radix_ascii_core_test;
    import i2ra_pkg::*;

    localparam int MAX_CYCLES   = 4_000_000;
    localparam int SETTLE_TICKS = 5000;  // longer than one 64-digit conversion
    localparam int SHOWN_ERRORS = 10;

    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              last;
    } text_char_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic [S_TUSER_W-1:0] s_tuser = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [CHAR_W-1:0]    m_tdata;
    logic                 m_tlast;

    text_char_t pending_chars[$];
    int         bad_chars = 0;
    int         cycle_count = 0;
    int         stall_left = 0;
    bit         idle_on = 1'b1;

    integer_to_radix_ascii_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= MAX_CYCLES) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // receiver back-pressure in random bursts, off once idle_on is cleared
    always @(posedge aclk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end else if (idle_on && aresetn && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 7);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        if (d < DIGIT_W'(10))
            return ZERO_CHAR + CHAR_W'(d);
        return ALPHA_CHAR + CHAR_W'(d) - CHAR_W'(10);
    endfunction

    // queues the characters one conversion should produce
    function automatic void predict_text(input logic [IN_VALUE_W-1:0] raw, input logic sgn,
                                         input logic [RADIX_IN_W-1:0] radix_req,
                                         input logic [LIMIT_W-1:0] limit_req);
        logic [VALUE_WIDTH-1:0] mag;
        logic [DIGIT_W-1:0]     digits[0:STORE_DEPTH-1];
        logic [VALUE_WIDTH-1:0] base;
        logic                   neg;
        int                     limit;
        int                     ndig;
        int                     emit;
        int                     pos;
        text_char_t             c;
        mag = raw[VALUE_WIDTH-1:0];
        if (radix_req < RADIX_MIN)
            base = VALUE_WIDTH'(RADIX_MIN);
        else if (radix_req > RADIX_MAX)
            base = VALUE_WIDTH'(RADIX_MAX);
        else
            base = VALUE_WIDTH'(radix_req);
        limit = (limit_req > MAX_CHARS) ? int'(MAX_CHARS) : int'(limit_req);
        neg = sgn && mag[VALUE_WIDTH-1];
        if (neg)
            mag = '0 - mag;
        ndig = 0;
        while (mag != 0 && ndig < STORE_DEPTH) begin
            digits[ndig] = DIGIT_W'(mag % base);
            mag = mag / base;
            ndig++;
        end
        if (ndig == 0) begin
            digits[0] = '0;
            ndig = 1;
        end
        emit = ndig + (neg ? 1 : 0);
        if (emit > limit)
            emit = limit;
        pos = ndig;
        for (int k = 0; k < emit; k++) begin
            if (neg && k == 0) begin
                c.ch = MINUS_CHAR;
            end else begin
                pos--;
                c.ch = digit_char(digits[pos]);
            end
            c.last = (k + 1 == emit);
            pending_chars.push_back(c);
        end
    endfunction

    // result checker
    always @(posedge aclk) begin
        text_char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_chars.size() == 0) begin
                bad_chars++;
                if (bad_chars <= SHOWN_ERRORS)
                    $display("unexpected char %h last %b", m_tdata, m_tlast);
            end else begin
                want = pending_chars.pop_front();
                if (m_tdata !== want.ch || m_tlast !== want.last) begin
                    bad_chars++;
                    if (bad_chars <= SHOWN_ERRORS)
                        $display("char mismatch: expected %h last %b, got %h last %b",
                                 want.ch, want.last, m_tdata, m_tlast);
                end
            end
        end
    end

    // sends one item; called and returning just after a rising edge
    task automatic convert_value(input logic [IN_VALUE_W-1:0] value, input logic sgn,
                                 input logic [RADIX_IN_W-1:0] radix_req,
                                 input logic [LIMIT_W-1:0] limit_req);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= S_TDATA_W'({limit_req, radix_req, value});
        s_tuser  <= sgn;
        do @(posedge aclk); while (!s_tready);
        predict_text(value, sgn, radix_req, limit_req);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (pending_chars.size() != 0);
    endtask

    function automatic logic [IN_VALUE_W-1:0] pick_value();
        logic [IN_VALUE_W-1:0] v;
        int                    w;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 4))
            0: ;
            1: begin
                w = $urandom_range(1, 64);
                v = v & ({IN_VALUE_W{1'b1}} >> (64 - w));
            end
            2: v[IN_VALUE_W-1] = 1'b1;
            3: v = IN_VALUE_W'($urandom_range(0, 300));
            default: v = '0 - IN_VALUE_W'($urandom_range(1, 300));
        endcase
        return v;
    endfunction

    task automatic test_corner_values();
        logic [IN_VALUE_W-1:0] ones;
        logic [IN_VALUE_W-1:0] most_neg;
        ones = '1;
        most_neg = {1'b1, {(IN_VALUE_W-1){1'b0}}};
        convert_value('0, 1'b0, 8'd10, 7'd64);
        convert_value('0, 1'b1, 8'd2, 7'd1);
        convert_value(ones, 1'b0, 8'd16, 7'd64);
        convert_value(ones, 1'b1, 8'd10, 7'd64);
        convert_value(most_neg, 1'b1, 8'd10, 7'd64);
        convert_value(~most_neg, 1'b1, 8'd10, 7'd64);
        convert_value(most_neg, 1'b0, 8'd10, 7'd64);
        convert_value(64'hFEDC_BA98_7654_3210, 1'b0, 8'd16, 7'd64);
        // radix below two and above sixteen clamp
        convert_value(64'd1234567, 1'b0, 8'd0, 7'd64);
        convert_value(64'd1234567, 1'b0, 8'd1, 7'd64);
        convert_value(64'd1234567, 1'b0, 8'd17, 7'd64);
        convert_value(64'd1234567, 1'b0, 8'd255, 7'd64);
        // 64 binary digits, then sign plus 64 digits cut at the limit
        convert_value(ones, 1'b0, 8'd2, 7'd64);
        convert_value(most_neg, 1'b1, 8'd2, 7'd127);
        // zero limit gives nothing, oversize limits clamp
        convert_value(64'd99, 1'b0, 8'd10, 7'd0);
        convert_value(64'd99, 1'b1, 8'd10, 7'd127);
        convert_value(ones, 1'b0, 8'd3, 7'd65);
        convert_value(ones, 1'b1, 8'd7, 7'd1);
        convert_value(64'd987654321, 1'b0, 8'd10, 7'd3);
        convert_value(64'd4095, 1'b0, 8'd8, 7'd4);
        convert_value(64'd35, 1'b0, 8'd12, 7'd2);
        convert_value(64'h5555_5555_5555_5555, 1'b1, 8'd13, 7'd64);
    endtask

    task automatic random_item();
        logic [RADIX_IN_W-1:0] r;
        logic [LIMIT_W-1:0]    l;
        r = ($urandom_range(0, 4) == 0) ? RADIX_IN_W'($urandom) :
                                          RADIX_IN_W'($urandom_range(2, 16));
        l = ($urandom_range(0, 4) == 0) ? LIMIT_W'($urandom) :
                                          LIMIT_W'($urandom_range(1, 64));
        convert_value(pick_value(), 1'($urandom), r, l);
    endtask

    task automatic test_random_values();
        repeat (100) random_item();
    endtask

    task automatic test_pause_until_drained();
        repeat (4) random_item();
        wait_drained();
        repeat (4) random_item();
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        repeat (12) random_item();
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_corner_values();
        test_random_values();
        test_pause_until_drained();
        test_back_to_back();
        wait_drained();
        repeat (SETTLE_TICKS) @(posedge aclk);
        if (pending_chars.size() != 0)
            $display("%0d expected chars never arrived", pending_chars.size());
        if (bad_chars == 0 && pending_chars.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
